/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold
`define ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/rrss_pkg.sv */
// ---------------------------------------------------------------------------
// rrss_pkg
// types and constants of the round-robin sleep scheduler
// ---------------------------------------------------------------------------
package rrss_pkg;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_EXEC    = 2'd2,
    SLOT_BLOCKED = 2'd3
  } slot_state_e;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECODE = 3'd1,
    S_SWEEP  = 3'd2,
    S_SCAN   = 3'd3,
    S_DONE   = 3'd4
  } ctrl_state_e;

  typedef struct packed {
    logic load_item;
    logic wr_slot;
    logic sweep_start;
    logic sweep_step;
    logic scan_start;
    logic scan_step;
    logic pick;
    logic go_idle;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic is_write;
    logic sweep_last;
    logic scan_hit;
    logic scan_last;
    logic out_busy;
  } sts_t;

endpackage

/* rtl/rrss_ctrl.sv */
// ---------------------------------------------------------------------------
// rrss_ctrl
// sequencer: decode, timer sweep, round-robin scan, result hand-off
// ---------------------------------------------------------------------------
module rrss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rrss_pkg::sts_t sts_i,
  output rrss_pkg::ctl_t ctl_o
);

  rrss_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrss_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rrss_pkg::S_IDLE: begin
        if (in_valid_i) state_d = rrss_pkg::S_DECODE;
      end
      rrss_pkg::S_DECODE: begin
        state_d = sts_i.is_write ? rrss_pkg::S_DONE : rrss_pkg::S_SWEEP;
      end
      rrss_pkg::S_SWEEP: begin
        if (sts_i.sweep_last) state_d = rrss_pkg::S_SCAN;
      end
      rrss_pkg::S_SCAN: begin
        if (sts_i.scan_hit || sts_i.scan_last) state_d = rrss_pkg::S_DONE;
      end
      rrss_pkg::S_DONE: begin
        if (!sts_i.out_busy) state_d = rrss_pkg::S_IDLE;
      end
      default: state_d = rrss_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rrss_pkg::S_IDLE: begin
        in_ready_o      = 1'b1;
        ctl_o.load_item = in_valid_i;
      end
      rrss_pkg::S_DECODE: begin
        ctl_o.wr_slot     = sts_i.is_write;
        ctl_o.sweep_start = !sts_i.is_write;
      end
      rrss_pkg::S_SWEEP: begin
        ctl_o.sweep_step = 1'b1;
        ctl_o.scan_start = sts_i.sweep_last;
      end
      rrss_pkg::S_SCAN: begin
        ctl_o.scan_step = 1'b1;
        ctl_o.pick      = sts_i.scan_hit;
        ctl_o.go_idle   = !sts_i.scan_hit && sts_i.scan_last;
      end
      rrss_pkg::S_DONE: begin
        ctl_o.out_load = !sts_i.out_busy;
      end
      default: begin
        ctl_o = '0;
      end
    endcase
  end

endmodule

/* rtl/rrss_datapath.sv */
// ---------------------------------------------------------------------------
// rrss_datapath
// slot tables, sweep and scan pointers, active slot and result register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rrss_datapath #(
  parameter int NUM_SLOTS  = 16,
  parameter int SLEEP_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rrss_pkg::ctl_t ctl_i,
  output rrss_pkg::sts_t sts_o,
  input  logic           cmd_i,
  input  logic [3:0]     slot_i,
  input  logic [1:0]     new_state_i,
  input  logic [15:0]    sleep_ticks_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           active_valid_o,
  output logic [3:0]     active_slot_o,
  output logic           switched_o,
  output logic [15:0]    woken_mask_o
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  // captured transaction
  logic                  cmd_q;
  logic [3:0]            slot_q;
  rrss_pkg::slot_state_e nst_q;
  logic [15:0]           ticks_q;

  // slot tables, one valid bit per slot covers both tables
  rrss_pkg::slot_state_e st_mem [NUM_SLOTS];
  logic [SLEEP_BITS-1:0] cnt_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  st_vld_q;

  logic                  st_we, cnt_we, rd_en;
  logic [IW-1:0]         st_waddr, cnt_waddr, rd_addr;
  rrss_pkg::slot_state_e st_wdata;
  logic [SLEEP_BITS-1:0] cnt_wdata;
  rrss_pkg::slot_state_e rd_st_q;
  logic [SLEEP_BITS-1:0] rd_cnt_q;
  logic                  rd_st_vld_q;

  // pointers and scheduler state
  logic [IW-1:0]         idx_q, cnt_q, next_idx, start_idx;
  logic [NUM_SLOTS-1:0]  ready_vec_q, woken_q;
  logic                  active_q, res_sw_q;
  logic [IW-1:0]         active_idx_q;

  // sweep evaluation
  rrss_pkg::slot_state_e cur_st, new_st;
  logic [SLEEP_BITS-1:0] cur_cnt, dec_cnt, new_cnt;
  logic                  wake;

  // write item decode
  logic [8:0]            slot_ext;
  logic                  slot_in_range;
  logic [IW-1:0]         slot_idx;

  // result register
  logic                  out_valid_q, o_act_q, o_sw_q;
  logic [3:0]            o_slot_q;
  logic [15:0]           o_woken_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_item) begin
      cmd_q   <= cmd_i;
      slot_q  <= slot_i;
      nst_q   <= rrss_pkg::slot_state_e'(new_state_i);
      ticks_q <= sleep_ticks_i;
    end
  end

  assign slot_ext      = 9'(slot_q);
  assign slot_in_range = slot_ext < 9'(NUM_SLOTS);
  assign slot_idx      = IW'(slot_ext);

  assign next_idx  = (idx_q == LAST_IDX) ? '0 : idx_q + IW'(1);
  assign start_idx = !active_q ? '0 :
                     (active_idx_q == LAST_IDX) ? '0 : active_idx_q + IW'(1);

  always_comb begin
    cur_st  = rd_st_vld_q ? rd_st_q : rrss_pkg::SLOT_EMPTY;
    cur_cnt = rd_st_vld_q ? rd_cnt_q : '0;
    dec_cnt = cur_cnt - SLEEP_BITS'(1);
    new_st  = cur_st;
    new_cnt = cur_cnt;
    wake    = 1'b0;
    if (cur_st == rrss_pkg::SLOT_BLOCKED && cur_cnt != '0) begin
      new_cnt = dec_cnt;
      if (dec_cnt == '0) begin
        new_st = rrss_pkg::SLOT_READY;
        wake   = 1'b1;
      end
    end
    if (active_q && idx_q == active_idx_q && new_st == rrss_pkg::SLOT_EXEC) begin
      new_st = rrss_pkg::SLOT_READY;
    end
  end

  always_comb begin
    st_we     = 1'b0;
    st_waddr  = idx_q;
    st_wdata  = new_st;
    cnt_we    = 1'b0;
    cnt_waddr = idx_q;
    cnt_wdata = new_cnt;
    if (ctl_i.wr_slot) begin
      st_we     = slot_in_range;
      st_waddr  = slot_idx;
      st_wdata  = nst_q;
      cnt_we    = slot_in_range;
      cnt_waddr = slot_idx;
      cnt_wdata = SLEEP_BITS'(ticks_q);
    end else if (ctl_i.sweep_step) begin
      st_we  = 1'b1;
      cnt_we = 1'b1;
    end else if (ctl_i.pick) begin
      st_we    = 1'b1;
      st_wdata = rrss_pkg::SLOT_EXEC;
    end
  end

  assign rd_en   = ctl_i.sweep_start || ctl_i.sweep_step;
  assign rd_addr = ctl_i.sweep_start ? '0 : next_idx;

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    if (rd_en) rd_st_q <= st_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (rd_en) rd_cnt_q <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q    <= '0;
      rd_st_vld_q <= 1'b0;
    end else begin
      if (st_we) st_vld_q[st_waddr] <= 1'b1;
      if (rd_en) begin
        rd_st_vld_q <= st_vld_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      cnt_q        <= '0;
      ready_vec_q  <= '0;
      woken_q      <= '0;
      active_q     <= 1'b0;
      active_idx_q <= '0;
      res_sw_q     <= 1'b0;
    end else begin
      if (ctl_i.sweep_start) begin
        idx_q <= '0;
      end else if (ctl_i.scan_start) begin
        idx_q <= start_idx;
      end else if (ctl_i.sweep_step || ctl_i.scan_step) begin
        idx_q <= next_idx;
      end
      if (ctl_i.scan_start) begin
        cnt_q <= '0;
      end else if (ctl_i.scan_step) begin
        cnt_q <= cnt_q + IW'(1);
      end
      if (ctl_i.sweep_step) begin
        ready_vec_q[idx_q] <= (new_st == rrss_pkg::SLOT_READY);
        if (wake) woken_q[idx_q] <= 1'b1;
      end
      if (ctl_i.load_item) begin
        woken_q  <= '0;
        res_sw_q <= 1'b0;
      end
      if (ctl_i.pick) begin
        active_q     <= 1'b1;
        active_idx_q <= idx_q;
        res_sw_q     <= !active_q || (active_idx_q != idx_q);
      end else if (ctl_i.go_idle) begin
        active_q     <= 1'b0;
        active_idx_q <= '0;
        res_sw_q     <= active_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      o_act_q   <= active_q;
      o_slot_q  <= 4'(active_idx_q);
      o_sw_q    <= res_sw_q;
      o_woken_q <= 16'(woken_q);
    end
  end

  assign sts_o.is_write   = (cmd_q == rrss_pkg::CMD_WRITE);
  assign sts_o.sweep_last = (idx_q == LAST_IDX);
  assign sts_o.scan_hit   = ready_vec_q[idx_q];
  assign sts_o.scan_last  = (cnt_q == LAST_IDX);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign active_valid_o = o_act_q;
  assign active_slot_o  = o_slot_q;
  assign switched_o     = o_sw_q;
  assign woken_mask_o   = o_woken_q;

  `ASSERT_NEVER(a_step_overlap, clk_i, rst_ni, ctl_i.sweep_step && ctl_i.scan_step)
  `ASSERT_IMPLY(a_pick_ready, clk_i, rst_ni, ctl_i.pick, ready_vec_q[idx_q])
  `ASSERT_IMPLY(a_idle_index, clk_i, rst_ni, !active_q, active_idx_q == '0)
  `ASSERT_NEXT(a_load_shows, clk_i, rst_ni, ctl_i.out_load, out_valid_q)

endmodule

/* rtl/round_robin_sleep_scheduler.sv */
// ---------------------------------------------------------------------------
// round_robin_sleep_scheduler
// round-robin task scheduler with per-slot sleep countdowns
// ---------------------------------------------------------------------------
// input channel (in_valid_i/in_ready_o) carries one command per transaction:
// a tick, or a write of one slot's state and sleep countdown. every input
// transaction gives exactly one result on the output channel
// (out_valid_o/out_ready_i): active slot, switch flag and woken mask.
// a write item goes from decode straight to the result. a tick first sweeps
// the sleep counters slot by slot through the slot tables, then the
// round-robin scan checks slots in turn, stopping at the first ready slot.
// one transaction is in flight at a time; in_ready_o is high while idle.
// the result sits in an output register, so the next transaction can be
// accepted while an earlier result waits; a stalled receiver holds the
// sequencer only when the next result is ready to be loaded.
// reset clears all slots to empty with zero count and makes the block idle;
// no clearing pass is needed, per-slot valid bits stand for the reset value.
// ---------------------------------------------------------------------------
module round_robin_sleep_scheduler #(
  parameter int NUM_SLOTS  = 16,
  parameter int SLEEP_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [3:0]  slot_i,
  input  logic [1:0]  new_state_i,
  input  logic [15:0] sleep_ticks_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        active_valid_o,
  output logic [3:0]  active_slot_o,
  output logic        switched_o,
  output logic [15:0] woken_mask_o
);

  rrss_pkg::ctl_t ctl;
  rrss_pkg::sts_t sts;

  rrss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  rrss_datapath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .SLEEP_BITS (SLEEP_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .cmd_i          (cmd_i),
    .slot_i         (slot_i),
    .new_state_i    (new_state_i),
    .sleep_ticks_i  (sleep_ticks_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .active_valid_o (active_valid_o),
    .active_slot_o  (active_slot_o),
    .switched_o     (switched_o),
    .woken_mask_o   (woken_mask_o)
  );

endmodule

/* test/rrss_checker.sv */
// ---------------------------------------------------------------------------
// rrss_checker
// watches both channels of the round-robin sleep scheduler, predicts each
// result from its own copy of the slot tables and compares in order
// ---------------------------------------------------------------------------
module rrss_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        cmd_i,
  input  logic [3:0]  slot_i,
  input  logic [1:0]  new_state_i,
  input  logic [15:0] sleep_ticks_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        active_valid_i,
  input  logic [3:0]  active_slot_i,
  input  logic        switched_i,
  input  logic [15:0] woken_mask_i,
  output int          errors_o,
  output int          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        active_valid;
    logic [3:0]  active_slot;
    logic        switched;
    logic [15:0] woken_mask;
  } sched_result_t;

  rrss_pkg::slot_state_e task_state [16];
  logic [15:0]           task_sleep [16];
  logic                  run_flag;
  logic [3:0]            run_idx;
  sched_result_t         sched_q [$];
  int                    err_cnt = 0;

  assign errors_o = err_cnt;

  initial outstanding_o = 0;

  function automatic sched_result_t schedule_step(logic cmd, logic [3:0] slot,
                                                  rrss_pkg::slot_state_e st,
                                                  logic [15:0] ticks);
    sched_result_t r;
    logic          old_flag;
    logic [3:0]    old_idx;
    logic [3:0]    start;
    logic [3:0]    k;
    logic [3:0]    pick;
    logic          found;
    r = '0;
    pick = '0;
    found = 1'b0;
    if (cmd == rrss_pkg::CMD_WRITE) begin
      task_state[slot] = st;
      task_sleep[slot] = ticks;
    end else begin
      // sleep countdown and wake-up
      for (int i = 0; i < 16; i++) begin
        if (task_state[i] == rrss_pkg::SLOT_BLOCKED && task_sleep[i] != 16'd0) begin
          task_sleep[i] = task_sleep[i] - 16'd1;
          if (task_sleep[i] == 16'd0) begin
            task_state[i] = rrss_pkg::SLOT_READY;
            r.woken_mask[i] = 1'b1;
          end
        end
      end
      old_flag = run_flag;
      old_idx  = run_idx;
      if (run_flag && task_state[run_idx] == rrss_pkg::SLOT_EXEC) begin
        task_state[run_idx] = rrss_pkg::SLOT_READY;
      end
      // round-robin pick, old active slot checked last
      start = run_flag ? run_idx + 4'd1 : 4'd0;
      for (int i = 0; i < 16; i++) begin
        k = start + 4'(i);
        if (!found && task_state[k] == rrss_pkg::SLOT_READY) begin
          found = 1'b1;
          pick  = k;
        end
      end
      if (found) begin
        run_flag = 1'b1;
        run_idx  = pick;
        task_state[pick] = rrss_pkg::SLOT_EXEC;
      end else begin
        run_flag = 1'b0;
        run_idx  = '0;
      end
      r.switched = (old_flag != run_flag) || (run_flag && old_idx != run_idx);
    end
    r.active_valid = run_flag;
    r.active_slot  = run_flag ? run_idx : 4'd0;
    return r;
  endfunction

  task automatic note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        task_state[i] = rrss_pkg::SLOT_EMPTY;
        task_sleep[i] = '0;
      end
      run_flag = 1'b0;
      run_idx  = '0;
      sched_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (sched_q.size() == 0) begin
          note_error($sformatf("unexpected transaction: valid=%0d slot=%0d sw=%0d woken=%h",
                               active_valid_i, active_slot_i, switched_i, woken_mask_i));
        end else begin
          want = sched_q.pop_front();
          if (active_valid_i !== want.active_valid || active_slot_i !== want.active_slot ||
              switched_i !== want.switched || woken_mask_i !== want.woken_mask) begin
            note_error($sformatf({"mismatch: expected valid=%0d slot=%0d sw=%0d woken=%h,",
                                  " got valid=%0d slot=%0d sw=%0d woken=%h"},
                                 want.active_valid, want.active_slot, want.switched,
                                 want.woken_mask, active_valid_i, active_slot_i,
                                 switched_i, woken_mask_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        sched_q.push_back(schedule_step(cmd_i, slot_i,
                                        rrss_pkg::slot_state_e'(new_state_i),
                                        sleep_ticks_i));
      end
    end
    outstanding_o <= sched_q.size();
  end

endmodule

/* test/tb.sv */
// ---------------------------------------------------------------------------
// tb
// drives the round-robin sleep scheduler with directed slot writes and ticks,
// then a long random mix, with random idling on both channels, a long
// receiver hold-off and a full drain pause; the checker judges every result
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS = 850;
  localparam int LIMIT = 400000;
  localparam int HOLD  = 300;
  localparam int DRAIN = 48;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        cmd_i;
  logic [3:0]  slot_i;
  logic [1:0]  new_state_i;
  logic [15:0] sleep_ticks_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        active_valid_o;
  logic [3:0]  active_slot_o;
  logic        switched_o;
  logic [15:0] woken_mask_o;

  int          errors;
  int          outstanding;
  int          cycle_cnt = 0;
  int          hold_cnt  = 0;
  logic        steady    = 1'b0;
  logic        hold_go   = 1'b0;

  round_robin_sleep_scheduler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .slot_i        (slot_i),
    .new_state_i   (new_state_i),
    .sleep_ticks_i (sleep_ticks_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .active_valid_o(active_valid_o),
    .active_slot_o (active_slot_o),
    .switched_o    (switched_o),
    .woken_mask_o  (woken_mask_o)
  );

  rrss_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .cmd_i         (cmd_i),
    .slot_i        (slot_i),
    .new_state_i   (new_state_i),
    .sleep_ticks_i (sleep_ticks_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .active_valid_i(active_valid_o),
    .active_slot_i (active_slot_o),
    .switched_i    (switched_o),
    .woken_mask_i  (woken_mask_o),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("FAIL round_robin_sleep_scheduler");
      $finish;
    end
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && hold_cnt < HOLD) begin
        out_ready_i = 1'b0;
        hold_cnt++;
      end else begin
        out_ready_i = steady || ($urandom_range(99) >= 33);
      end
    end
  end

  task automatic send_cmd(logic cmd, logic [3:0] slot, rrss_pkg::slot_state_e st,
                          logic [15:0] ticks);
    if (!steady) begin
      while ($urandom_range(99) < 33) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i    = 1'b1;
    cmd_i         = cmd;
    slot_i        = slot;
    new_state_i   = st;
    sleep_ticks_i = ticks;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // tick with random don't-care fields
  task automatic issue_tick();
    send_cmd(rrss_pkg::CMD_TICK, 4'($urandom),
             rrss_pkg::slot_state_e'($urandom_range(3)), 16'($urandom));
  endtask

  initial begin
    int                    sel;
    int                    wsel;
    int                    tsel;
    rrss_pkg::slot_state_e st;
    logic [15:0]           ticks;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = rrss_pkg::CMD_TICK;
    slot_i        = '0;
    new_state_i   = rrss_pkg::SLOT_EMPTY;
    sleep_ticks_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: wrap-around, wake-ups, stuck sleepers, rewrites, idle edges
    issue_tick();
    send_cmd(rrss_pkg::CMD_WRITE, 4'd0, rrss_pkg::SLOT_READY, 16'h0000);
    send_cmd(rrss_pkg::CMD_WRITE, 4'd15, rrss_pkg::SLOT_READY, 16'hFFFF);
    issue_tick();
    issue_tick();
    issue_tick();
    send_cmd(rrss_pkg::CMD_WRITE, 4'd3, rrss_pkg::SLOT_BLOCKED, 16'd1);
    send_cmd(rrss_pkg::CMD_WRITE, 4'd4, rrss_pkg::SLOT_BLOCKED, 16'd2);
    send_cmd(rrss_pkg::CMD_WRITE, 4'd5, rrss_pkg::SLOT_BLOCKED, 16'd0);
    send_cmd(rrss_pkg::CMD_WRITE, 4'd7, rrss_pkg::SLOT_EXEC, 16'h5555);
    issue_tick();
    issue_tick();
    send_cmd(rrss_pkg::CMD_WRITE, 4'd15, rrss_pkg::SLOT_EMPTY, 16'd0);
    send_cmd(rrss_pkg::CMD_WRITE, 4'd0, rrss_pkg::SLOT_EMPTY, 16'd0);
    send_cmd(rrss_pkg::CMD_WRITE, 4'd3, rrss_pkg::SLOT_EMPTY, 16'd0);
    issue_tick();
    send_cmd(rrss_pkg::CMD_WRITE, 4'd4, rrss_pkg::SLOT_BLOCKED, 16'd0);
    issue_tick();
    issue_tick();
    send_cmd(rrss_pkg::CMD_WRITE, 4'd9, rrss_pkg::SLOT_BLOCKED, 16'd3);
    issue_tick();
    issue_tick();
    issue_tick();
    send_cmd(rrss_pkg::CMD_WRITE, 4'd9, rrss_pkg::SLOT_EXEC, 16'hAAAA);
    issue_tick();

    // random mix, mostly short sleeps so slots keep waking
    for (int n = 0; n < ITEMS; n++) begin
      steady = (n >= 500 && n < 650);
      if (n == 200) hold_go = 1'b1;
      if (n == 400) begin
        in_valid_i = 1'b0;
        while (outstanding != 0) @(posedge clk_i);
        @(negedge clk_i);
      end
      sel = $urandom_range(99);
      if (sel < 45) begin
        issue_tick();
      end else begin
        wsel = $urandom_range(99);
        if (wsel < 40)      st = rrss_pkg::SLOT_BLOCKED;
        else if (wsel < 75) st = rrss_pkg::SLOT_READY;
        else if (wsel < 90) st = rrss_pkg::SLOT_EMPTY;
        else                st = rrss_pkg::SLOT_EXEC;
        tsel = $urandom_range(99);
        if (tsel < 70)      ticks = 16'($urandom_range(6));
        else if (tsel < 90) ticks = 16'($urandom);
        else if (tsel < 95) ticks = 16'hFFFF;
        else                ticks = 16'h0000;
        send_cmd(rrss_pkg::CMD_WRITE, 4'($urandom), st, ticks);
      end
    end
    steady = 1'b0;
    in_valid_i = 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0 && outstanding == 0) begin
      $display("PASS round_robin_sleep_scheduler");
    end else begin
      $display("FAIL round_robin_sleep_scheduler");
    end
    $finish;
  end

endmodule
